@@ hw/rtl/sbl_pkg.sv @@
`default_nettype none

package sbl_pkg;

   localparam int MODE_W       = 2;
   localparam int KEY_W        = 8;
   localparam int INDEX_W      = 4;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 5;
   localparam int DEF_CAPACITY = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2,
      STATUS_RANGE   = 2'd3
   } status_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic             ins_en;
      logic             del_en;
      logic [KEY_W-1:0] key;
   } sbl_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/sbl_req_if.sv @@
`default_nettype none

interface sbl_req_if;
   import sbl_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [KEY_W-1:0]   key;
   logic [INDEX_W-1:0] index;

   modport source (output valid, output mode, output key, output index, input ready);
   modport sink   (input valid, input mode, input key, input index, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sbl_rsp_if.sv @@
`default_nettype none

interface sbl_rsp_if;
   import sbl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    value;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output status, output value, output count, input ready);
   modport sink   (input valid, input status, input value, input count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sbl_cell.sv @@
`default_nettype none

module sbl_cell (
   input  logic                     clock,
   input  sbl_pkg::sbl_ctl_type     ctl,
   input  logic                     valid,
   input  logic [sbl_pkg::KEY_W-1:0] left_key,
   input  logic                     left_less,
   input  logic [sbl_pkg::KEY_W-1:0] right_key,
   input  logic                     hit_in,
   output logic [sbl_pkg::KEY_W-1:0] key,
   output logic                     less,
   output logic                     hit_out
);
   import sbl_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;

   assign less    = valid && (key_ff < ctl.key);
   // first match at or left of this cell: close the gap by pulling from the right
   assign hit_out = hit_in || (valid && (key_ff == ctl.key));
   assign key     = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.ins_en && !less) begin
         // left neighbor smaller (or chain head): this is the insert slot
         key_in = left_less ? ctl.key : left_key;
      end else if (ctl.del_en && hit_out) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_byte_list_unit.sv @@
`default_nettype none

// Sorted byte list: keeps up to CAPACITY byte keys in ascending order.
// Request words (req_ch) carry mode, key and index: insert places the key ahead
// of the first stored key that is not smaller, delete removes the first equal
// key, read returns the key at index. Each request yields one response word
// (rsp_ch) with status, value and the entry count after the operation.
// The keys sit in a chain of cells; every cell compares its key against the
// request key in parallel and shifts one place left or right.
// The response is registered and valid the cycle after the request is taken.
// Throughput: one word per cycle; a request is taken whenever the response
// register is empty or being drained in the same cycle.
// When the receiver stalls, the response holds and req_ch.ready drops until
// it is taken. Reset empties the list and the response register at once;
// the stored key values themselves are not cleared and are never visible.
module sorted_byte_list_unit #(
   parameter int CAPACITY = sbl_pkg::DEF_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   sbl_req_if.sink   req_ch,
   sbl_rsp_if.source rsp_ch
);
   import sbl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [KEY_W-1:0]    value_ff;
   logic [KEY_W-1:0]    value_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [COUNT_W-1:0]  rsp_count_in;

   logic                accept;
   mode_type            mode;
   logic                full;
   logic                found;
   logic                in_range;
   sbl_ctl_type         ctl;
   logic [CNT_W+COUNT_W-1:0] count_ext;
   logic [CNT_W+INDEX_W-1:0] index_ext;
   logic [CNT_W+INDEX_W-1:0] count_cmp;

   logic [KEY_W-1:0]    cell_key  [CAPACITY];
   logic [CAPACITY-1:0] cell_less;
   logic [CAPACITY-1:0] cell_hit;
   logic [KEY_W-1:0]    read_key;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign mode         = mode_type'(req_ch.mode);
   assign full         = count_ff >= CNT_W'(CAPACITY);
   assign found        = cell_hit[CAPACITY-1];

   assign ctl.key    = req_ch.key;
   assign ctl.ins_en = accept && (mode == MODE_INSERT) && !full;
   assign ctl.del_en = accept && (mode == MODE_DELETE) && found;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [KEY_W-1:0] left_key;
         logic             left_less;
         logic [KEY_W-1:0] right_key;
         logic             hit_in;

         if (g == 0) begin : g_head
            assign left_key  = '0;
            assign left_less = 1'b1;
            assign hit_in    = 1'b0;
         end else begin : g_body
            assign left_key  = cell_key[g-1];
            assign left_less = cell_less[g-1];
            assign hit_in    = cell_hit[g-1];
         end

         if (g == CAPACITY - 1) begin : g_tail
            assign right_key = '0;
         end else begin : g_inner
            assign right_key = cell_key[g+1];
         end

         sbl_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .valid     (count_ff > CNT_W'(g)),
            .left_key  (left_key),
            .left_less (left_less),
            .right_key (right_key),
            .hit_in    (hit_in),
            .key       (cell_key[g]),
            .less      (cell_less[g]),
            .hit_out   (cell_hit[g])
         );
      end
   endgenerate

   // read port: index below the count also implies index below CAPACITY
   assign index_ext = {{CNT_W{1'b0}}, req_ch.index};
   assign count_cmp = {{INDEX_W{1'b0}}, count_ff};
   assign in_range  = index_ext < count_cmp;

   always_comb begin
      read_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (index_ext == (CNT_W+INDEX_W)'(i)) begin
            read_key = read_key | cell_key[i];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      value_in  = '0;
      case (mode)
         MODE_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_DELETE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_MISSING;
            end
         end
         MODE_READ: begin
            if (in_range) begin
               value_in = read_key;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   assign count_ext    = {{COUNT_W{1'b0}}, count_in};
   assign rsp_count_in = count_ext[COUNT_W-1:0];
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         value_ff     <= value_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.value  = value_ff;
   assign rsp_ch.count  = rsp_count_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_INSERT) && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add an entry");

   a_empty_delete: assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_DELETE) && (count_ff == '0)
      |=> rsp_ch.valid && (rsp_ch.status == STATUS_MISSING))
      else $error("delete on empty list not reported");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while response stalled");
`endif

endmodule

`default_nettype wire
